[hdl/gdt_pkg.sv]
// Shared constants, codes and helpers for the depth-first graph walker.
package gdt_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int MAX_DEGREE   = 16;

   localparam int VTX_W  = 4;                                // vertex fields
   localparam int VCNT_W = 5;                                // vertex_count register
   localparam int VI_W   = $clog2(MAX_VERTICES);             // vertex index
   localparam int HGT_W  = $clog2(MAX_VERTICES + 1);         // stack height, root counter
   localparam int DI_W   = $clog2(MAX_DEGREE);               // list slot index
   localparam int DCNT_W = $clog2(MAX_DEGREE + 1);           // list fill count
   localparam int AW     = $clog2(MAX_VERTICES * MAX_DEGREE);
   localparam int CMP_W  = 7;                                // common compare width

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] KIND_ENTER = 3'd0;
   localparam logic [2:0] KIND_TREE  = 3'd1;
   localparam logic [2:0] KIND_LEAVE = 3'd2;
   localparam logic [2:0] KIND_COMP  = 3'd3;
   localparam logic [2:0] KIND_ACK   = 3'd4;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   localparam logic [0:0] CSR_VCOUNT = 1'd0;

   function automatic logic [AW-1:0] mem_addr(input logic [VI_W-1:0] v,
                                              input logic [DI_W-1:0] i);
      mem_addr = AW'(AW'(v) * AW'(MAX_DEGREE) + AW'(i));
   endfunction
endpackage

[hdl/gdt_if.sv]
// Request and response channel interfaces of the graph walker.
interface gdt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [3:0] vertex_a;
   logic [3:0] vertex_b;
   modport source (output valid, cmd, vertex_a, vertex_b, input ready);
   modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

interface gdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [3:0] vertex;
   logic [3:0] neighbor;
   logic [3:0] depth;
   logic [1:0] status;
   logic       last;
   modport source (output valid, kind, vertex, neighbor, depth, status, last, input ready);
   modport sink   (input valid, kind, vertex, neighbor, depth, status, last, output ready);
endinterface

[hdl/graph_dfs_tree_walker.sv]
// Depth-first walker over an undirected graph held as per-vertex neighbour lists.
//
//   channel   direction  handshake            contents
//   req_ch    in         valid/ready          cmd, vertex_a, vertex_b
//   rsp_ch    out        valid/ready          kind, vertex, neighbor, depth, status, last
//   csr_*     in/out     APB, pready tied 1   vertex_count at address 0
//
// One request is worked on at a time by a small sequencer around a neighbour memory
// with a write port and a registered read port; req_ch.ready is high only when idle.
// An add reads and compares each entry of the vertex_a list, then makes a final
// count check, the room check with the first write, the second write and the
// acknowledge; a clear, a refused vertex or the unused command goes straight to
// the acknowledge. A run probes each root in turn, reads and looks at each list
// entry scanned and emits its events one by one. A stalled response holds the
// sequencer in place. Reset clears counts, marks and stack height at once.
module graph_dfs_tree_walker (
   input  logic              clock,
   input  logic              reset,
   gdt_req_if.sink           req_ch,
   gdt_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import gdt_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_ADD_RD = 4'd1, S_ADD_CMP = 4'd2,
                          S_ROOM = 4'd3, S_WR2 = 4'd4, S_ACK = 4'd5,
                          S_ROOT = 4'd6, S_LOOP = 4'd7, S_LOOK = 4'd8, S_PUSH = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [VTX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [DCNT_W-1:0] idx_ff, idx_in;
   logic [1:0]        stat_ff, stat_in;
   logic [HGT_W-1:0]  root_ff, root_in, height_ff, height_in;
   logic [VCNT_W-1:0] vcount_ff, vcount_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [DCNT_W-1:0] ncount_ff [MAX_VERTICES];
   logic [DCNT_W-1:0] ncount_in [MAX_VERTICES];
   logic [VTX_W-1:0]  stk_v_ff [MAX_VERTICES];
   logic [VTX_W-1:0]  stk_v_in [MAX_VERTICES];
   logic [DCNT_W-1:0] stk_p_ff [MAX_VERTICES];
   logic [DCNT_W-1:0] stk_p_in [MAX_VERTICES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [3:0]        vtx_ff, vtx_in, nbr_ff, nbr_in, dep_ff, dep_in;
   logic [1:0]        rstat_ff, rstat_in;
   logic              last_ff, last_in;

   // Neighbour memory: one write and one registered read a cycle.
   logic [VTX_W-1:0]  mem [MAX_VERTICES*MAX_DEGREE];
   logic [VTX_W-1:0]  rd_ff;
   logic              rd_en, we;
   logic [AW-1:0]     raddr, waddr;
   logic [VTX_W-1:0]  wdata;

   logic              out_free, emit, csr_wr;
   logic [CMP_W-1:0]  cnt_lim;
   logic [VI_W-1:0]   a_i, b_i, w_i, top_i, h_i, r_i;
   logic [DCNT_W-1:0] ca, cb, pos;
   logic              unvisited_left;

   always_comb begin
      if (vcount_ff == '0) cnt_lim = CMP_W'(1);
      else if (CMP_W'(vcount_ff) > CMP_W'(MAX_VERTICES)) cnt_lim = CMP_W'(MAX_VERTICES);
      else cnt_lim = CMP_W'(vcount_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign a_i   = a_ff[VI_W-1:0];
   assign b_i   = b_ff[VI_W-1:0];
   assign w_i   = rd_ff[VI_W-1:0];
   assign top_i = VI_W'(height_ff - HGT_W'(1));
   assign h_i   = height_ff[VI_W-1:0];
   assign r_i   = root_ff[VI_W-1:0];
   assign ca    = ncount_ff[a_i];
   assign cb    = ncount_ff[b_i];
   assign pos   = stk_p_ff[top_i];

   // Any vertex above the current root still unvisited means more components follow.
   always_comb begin
      unvisited_left = 1'b0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (CMP_W'(j) > CMP_W'(root_ff) && CMP_W'(j) < cnt_lim && !visited_ff[j])
            unvisited_left = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      idx_in     = idx_ff;
      stat_in    = stat_ff;
      root_in    = root_ff;
      height_in  = height_ff;
      visited_in = visited_ff;
      ncount_in  = ncount_ff;
      stk_v_in   = stk_v_ff;
      stk_p_in   = stk_p_ff;
      rd_en = 1'b0;
      raddr = '0;
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      emit     = 1'b0;
      kind_in  = kind_ff;
      vtx_in   = vtx_ff;
      nbr_in   = nbr_ff;
      dep_in   = dep_ff;
      rstat_in = rstat_ff;
      last_in  = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               a_in   = req_ch.vertex_a;
               b_in   = req_ch.vertex_b;
               stat_in = ST_DONE;
               state_in = S_ACK;
               case (req_ch.cmd)
                  CMD_ADD: begin
                     if (CMP_W'(req_ch.vertex_a) >= cnt_lim ||
                         CMP_W'(req_ch.vertex_b) >= cnt_lim) begin
                        stat_in = ST_BAD;
                     end else begin
                        idx_in   = '0;
                        state_in = S_ADD_RD;
                     end
                  end
                  CMD_RUN: begin
                     visited_in = '0;
                     height_in  = '0;
                     root_in    = '0;
                     state_in   = S_ROOT;
                  end
                  CMD_CLEAR: begin
                     for (int j = 0; j < MAX_VERTICES; j++) ncount_in[j] = '0;
                     visited_in = '0;
                     height_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_ADD_RD: begin
            if (idx_ff == ca) begin
               state_in = S_ROOM;
            end else begin
               rd_en    = 1'b1;
               raddr    = mem_addr(a_i, idx_ff[DI_W-1:0]);
               state_in = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            if (rd_ff == b_ff) begin
               stat_in  = ST_DUP;
               state_in = S_ACK;
            end else begin
               idx_in   = idx_ff + DCNT_W'(1);
               state_in = S_ADD_RD;
            end
         end
         S_ROOM: begin
            if (a_ff == b_ff ? (CMP_W'(ca) + CMP_W'(2) > CMP_W'(MAX_DEGREE))
                             : (CMP_W'(ca) + CMP_W'(1) > CMP_W'(MAX_DEGREE) ||
                                CMP_W'(cb) + CMP_W'(1) > CMP_W'(MAX_DEGREE))) begin
               stat_in  = ST_FULL;
               state_in = S_ACK;
            end else begin
               we       = 1'b1;
               waddr    = mem_addr(a_i, ca[DI_W-1:0]);
               wdata    = b_ff;
               state_in = S_WR2;
            end
         end
         S_WR2: begin
            we    = 1'b1;
            wdata = a_ff;
            if (a_ff == b_ff) begin
               waddr = mem_addr(a_i, DI_W'(ca + DCNT_W'(1)));
               ncount_in[a_i] = ca + DCNT_W'(2);
            end else begin
               waddr = mem_addr(b_i, cb[DI_W-1:0]);
               ncount_in[a_i] = ca + DCNT_W'(1);
               ncount_in[b_i] = cb + DCNT_W'(1);
            end
            stat_in  = ST_DONE;
            state_in = S_ACK;
         end
         S_ACK: begin
            if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_ACK; vtx_in = '0; nbr_in = '0; dep_in = '0;
               rstat_in = stat_ff; last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ROOT: begin
            if (visited_ff[r_i]) begin
               root_in = root_ff + HGT_W'(1);
            end else if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_ENTER; vtx_in = VTX_W'(root_ff); nbr_in = '0; dep_in = '0;
               rstat_in = ST_DONE; last_in = 1'b0;
               stk_v_in[h_i] = VTX_W'(root_ff);
               stk_p_in[h_i] = ncount_ff[r_i];
               visited_in[r_i] = 1'b1;
               height_in = height_ff + HGT_W'(1);
               state_in  = S_LOOP;
            end
         end
         S_LOOP: begin
            if (height_ff == '0) begin
               if (out_free) begin
                  emit = 1'b1;
                  kind_in = KIND_COMP; vtx_in = VTX_W'(root_ff); nbr_in = '0; dep_in = '0;
                  rstat_in = ST_DONE; last_in = !unvisited_left;
                  root_in  = root_ff + HGT_W'(1);
                  state_in = unvisited_left ? S_ROOT : S_IDLE;
               end
            end else if (pos != '0 && CMP_W'(pos) <= CMP_W'(MAX_DEGREE)) begin
               stk_p_in[top_i] = pos - DCNT_W'(1);
               rd_en    = 1'b1;
               raddr    = mem_addr(stk_v_ff[top_i][VI_W-1:0], DI_W'(pos - DCNT_W'(1)));
               state_in = S_LOOK;
            end else if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_LEAVE; vtx_in = stk_v_ff[top_i]; nbr_in = '0;
               dep_in = 4'(top_i); rstat_in = ST_DONE; last_in = 1'b0;
               height_in = height_ff - HGT_W'(1);
            end
         end
         S_LOOK: begin
            if (CMP_W'(rd_ff) < cnt_lim && !visited_ff[w_i] &&
                CMP_W'(height_ff) < CMP_W'(MAX_VERTICES)) begin
               if (out_free) begin
                  emit = 1'b1;
                  kind_in = KIND_TREE; vtx_in = stk_v_ff[top_i]; nbr_in = rd_ff;
                  dep_in = 4'(top_i); rstat_in = ST_DONE; last_in = 1'b0;
                  state_in = S_PUSH;
               end
            end else begin
               state_in = S_LOOP;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_ENTER; vtx_in = rd_ff; nbr_in = '0;
               dep_in = 4'(height_ff); rstat_in = ST_DONE; last_in = 1'b0;
               stk_v_in[h_i] = rd_ff;
               stk_p_in[h_i] = ncount_ff[w_i];
               visited_in[w_i] = 1'b1;
               height_in = height_ff + HGT_W'(1);
               state_in  = S_LOOP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Configuration port: a single register, written in the APB access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign vcount_in  = (csr_wr && csr_paddr[2] == CSR_VCOUNT) ? csr_pwdata[VCNT_W-1:0]
                                                                 : vcount_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_VCOUNT) ? 32'(vcount_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         height_ff    <= '0;
         visited_ff   <= '0;
         vcount_ff    <= VCNT_W'(MAX_VERTICES);
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_VERTICES; j++) ncount_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         visited_ff   <= visited_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         ncount_ff    <= ncount_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      idx_ff   <= idx_in;
      stat_ff  <= stat_in;
      root_ff  <= root_in;
      stk_v_ff <= stk_v_in;
      stk_p_ff <= stk_p_in;
      kind_ff  <= kind_in;
      vtx_ff   <= vtx_in;
      nbr_ff   <= nbr_in;
      dep_ff   <= dep_in;
      rstat_ff <= rstat_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rd_ff <= mem[raddr];
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.kind     = kind_ff;
   assign rsp_ch.vertex   = vtx_ff;
   assign rsp_ch.neighbor = nbr_ff;
   assign rsp_ch.depth    = dep_ff;
   assign rsp_ch.status   = rstat_ff;
   assign rsp_ch.last     = last_ff;

   // The walk stack never grows past the vertex limit.
   a_height: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(height_ff) <= CMP_W'(MAX_VERTICES))
      else $error("walk stack overflow");

   // An accepted request always moves the sequencer out of idle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != S_IDLE)
      else $error("request accepted without leaving idle");

   // Every acknowledge is the single and final response of its request.
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ACK |-> last_ff)
      else $error("acknowledge without last");

   // A walk can only finish on a component end.
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff && kind_ff != KIND_ACK |-> kind_ff == KIND_COMP)
      else $error("walk ended on a non-component event");
endmodule
